// ===== hw/rtl/csq_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csq_pkg - shared types and constants
// Command and result codes, count limits and the decoded operation record
// passed from the front end to the execution back end.
// ---------------------------------------------------------------------------
package csq_pkg;

  localparam int TID_W   = 8;   // thread id port width
  localparam int KIND_W  = 3;
  localparam int CMD_W   = 2;
  localparam int IV_W    = 15;  // initial value register width
  localparam int COUNT_W = 16;

  localparam logic signed [COUNT_W-1:0] COUNT_MIN = 16'sh8000;
  localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sh7fff;

  localparam logic [CMD_W-1:0] CMD_WAIT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SIGNAL = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLOSE  = 2'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_OK       = 3'd0,
    KIND_BLOCKED  = 3'd1,
    KIND_RELEASED = 3'd2,
    KIND_CLOSED   = 3'd3,
    KIND_FULL     = 3'd4,
    KIND_OVERFLOW = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    OP_WAIT   = 2'd0,
    OP_SIGNAL = 2'd1,
    OP_CLOSE  = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [TID_W-1:0] tid;
  } op_t;

endpackage

// ===== hw/rtl/csq_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csq_front - command intake
// Accepts items from the input channel, decodes the command and pushes the
// decoded operation into the operation queue.
// ---------------------------------------------------------------------------
module csq_front (
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [csq_pkg::CMD_W-1:0] cmd_i,
  input  logic [csq_pkg::TID_W-1:0] thread_id_i,
  input  logic                      q_full_i,
  output logic                      q_push_o,
  output csq_pkg::op_t              q_data_o
);

  csq_pkg::op_e op;

  always_comb begin
    case (cmd_i)
      csq_pkg::CMD_WAIT:   op = csq_pkg::OP_WAIT;
      csq_pkg::CMD_SIGNAL: op = csq_pkg::OP_SIGNAL;
      csq_pkg::CMD_CLOSE:  op = csq_pkg::OP_CLOSE;
      default:             op = csq_pkg::OP_NOP;
    endcase
  end

  assign in_stall_o   = q_full_i;
  assign q_push_o     = in_valid_i && !q_full_i;
  assign q_data_o.op  = op;
  assign q_data_o.tid = thread_id_i;

endmodule

// ===== hw/rtl/csq_fifo.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csq_fifo - two-entry operation queue
// Decouples command intake from execution so either side can stall alone.
// ---------------------------------------------------------------------------
module csq_fifo (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  csq_pkg::op_t data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output csq_pkg::op_t data_o
);

  csq_pkg::op_t entry_q [2];
  logic         wr_q, wr_d;
  logic         rd_q, rd_d;
  logic [1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = entry_q[rd_q];

  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop_i  ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== hw/rtl/csq_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csq_back - semaphore execution
// Holds count, closed flag and the waiter ring, carries out one operation
// at a time and drives the registered result channel.
// ---------------------------------------------------------------------------
module csq_back #(
  parameter int QUEUE_DEPTH = 32,
  parameter int TID_KEEP_W  = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [csq_pkg::IV_W-1:0]   cfg_wdata_i,
  input  logic                       op_valid_i,
  input  csq_pkg::op_t               op_i,
  output logic                       op_pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [csq_pkg::KIND_W-1:0] kind_o,
  output logic [csq_pkg::TID_W-1:0]  thread_id_res_o,
  output logic                       last_o
);

  localparam int PtrW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FillW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0]  PtrLast = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [FillW-1:0] FillMax = FillW'(QUEUE_DEPTH);
  localparam logic [FillW-1:0] FillOne = FillW'(1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_REL  = 4'b0100,
    S_STAT = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic signed [csq_pkg::COUNT_W-1:0] count_q, count_d;
  logic             closed_q, closed_d;
  logic             is_close_q, is_close_d;
  logic [PtrW-1:0]  head_q, head_d, tail_q, tail_d;
  logic [FillW-1:0] fill_q, fill_d;

  logic [TID_KEEP_W-1:0] mem_q [QUEUE_DEPTH];
  logic [TID_KEEP_W-1:0] rdata_q;
  logic                  mem_we;

  logic                       out_valid_q;
  logic [csq_pkg::KIND_W-1:0] kind_q;
  logic [csq_pkg::TID_W-1:0]  tid_q;
  logic                       last_q;

  logic                       load;
  csq_pkg::kind_e             ld_kind;
  logic [csq_pkg::TID_W-1:0]  ld_tid;
  logic                       ld_last;
  logic                       slot_free;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    return (p == PtrLast) ? '0 : p + 1'b1;
  endfunction

  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    closed_d   = closed_q;
    is_close_d = is_close_q;
    head_d     = head_q;
    tail_d     = tail_q;
    fill_d     = fill_q;
    mem_we     = 1'b0;
    load       = 1'b0;
    ld_kind    = csq_pkg::KIND_OK;
    ld_tid     = '0;
    ld_last    = 1'b1;
    op_pop_o   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (op_valid_i && slot_free) begin
          op_pop_o = 1'b1;
          load     = 1'b1;
          case (op_i.op)
            csq_pkg::OP_WAIT: begin
              if (closed_q) begin
                ld_kind = csq_pkg::KIND_CLOSED;
              end else if (count_q == csq_pkg::COUNT_MIN) begin
                ld_kind = csq_pkg::KIND_OVERFLOW;
              end else if (count_q[csq_pkg::COUNT_W-1] || count_q == '0) begin
                if (fill_q >= FillMax) begin
                  ld_kind = csq_pkg::KIND_FULL;
                end else begin
                  count_d = count_q - 16'sd1;
                  mem_we  = 1'b1;
                  tail_d  = next_ptr(tail_q);
                  fill_d  = fill_q + 1'b1;
                  ld_kind = csq_pkg::KIND_BLOCKED;
                  ld_tid  = csq_pkg::TID_W'(op_i.tid[TID_KEEP_W-1:0]);
                  ld_last = 1'b0;
                  state_d = S_STAT;
                end
              end else begin
                count_d = count_q - 16'sd1;
              end
            end
            csq_pkg::OP_SIGNAL: begin
              if (count_q == csq_pkg::COUNT_MAX) begin
                ld_kind = csq_pkg::KIND_OVERFLOW;
              end else begin
                count_d = count_q + 16'sd1;
                // new count not positive and someone waiting: release head
                if (count_q[csq_pkg::COUNT_W-1] && fill_q != '0) begin
                  load       = 1'b0;
                  is_close_d = 1'b0;
                  state_d    = S_READ;
                end
              end
            end
            csq_pkg::OP_CLOSE: begin
              if (closed_q) begin
                ld_kind = csq_pkg::KIND_CLOSED;
              end else begin
                closed_d = 1'b1;
                if (fill_q != '0) begin
                  load       = 1'b0;
                  is_close_d = 1'b1;
                  state_d    = S_READ;
                end else begin
                  head_d = '0;
                  tail_d = '0;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        state_d = S_REL;
      end
      S_REL: begin
        if (slot_free) begin
          load    = 1'b1;
          ld_kind = csq_pkg::KIND_RELEASED;
          ld_tid  = csq_pkg::TID_W'(rdata_q);
          ld_last = 1'b0;
          head_d  = next_ptr(head_q);
          fill_d  = fill_q - 1'b1;
          if (is_close_q && fill_q != FillOne) begin
            state_d = S_READ;
          end else begin
            if (is_close_q) begin
              head_d = '0;
              tail_d = '0;
            end
            state_d = S_STAT;
          end
        end
      end
      S_STAT: begin
        if (slot_free) begin
          load    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      count_d  = {1'b0, cfg_wdata_i};
      closed_d = 1'b0;
      head_d   = '0;
      tail_d   = '0;
      fill_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      closed_q    <= 1'b0;
      is_close_q  <= 1'b0;
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      closed_q   <= closed_d;
      is_close_q <= is_close_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      fill_q     <= fill_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= ld_kind;
      tid_q  <= ld_tid;
      last_q <= ld_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[tail_q] <= op_i.tid[TID_KEEP_W-1:0];
    end
    rdata_q <= mem_q[head_q];
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign thread_id_res_o = tid_q;
  assign last_o          = last_q;

endmodule

// ===== hw/rtl/counting_semaphore_wait_queue_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// counting_semaphore_wait_queue_top - counting semaphore with FIFO wait queue
// Wait, signal and close commands on a counting semaphore; blocked threads
// are queued in arrival order and released by signal or close.
// ---------------------------------------------------------------------------
//
//  channel | handshake               | payload
//  --------+-------------------------+---------------------------------------
//  in      | in_valid_i / in_stall_o | cmd_i, thread_id_i
//  out     | out_valid_o/out_stall_i | kind_o, thread_id_res_o, last_o
//  cfg     | cfg_we_i                | cfg_wdata_i (initial count)
//
//  Sequence: wait, nop and every single-result command give one result;
//  a blocking wait gives the blocked item, then the status. A signal that
//  releases a waiter goes through read, release and status states: the
//  ring read is registered. Close is accepted, then releases each queued
//  waiter in turn (read, release), then gives the status.
//  Reset clears the count, a cfg write loads it; both open the semaphore
//  and empty the ring; no clearing pass is needed. The two-entry
//  operation queue keeps intake going, until full, while results stall.
//
// ---------------------------------------------------------------------------
module counting_semaphore_wait_queue_top #(
  parameter int QUEUE_DEPTH    = 32,
  parameter int THREAD_ID_BITS = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration
  input  logic                       cfg_we_i,
  input  logic [csq_pkg::IV_W-1:0]   cfg_wdata_i,
  // command items
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [csq_pkg::CMD_W-1:0]  cmd_i,
  input  logic [csq_pkg::TID_W-1:0]  thread_id_i,
  // result items
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [csq_pkg::KIND_W-1:0] kind_o,
  output logic [csq_pkg::TID_W-1:0]  thread_id_res_o,
  output logic                       last_o
);

  // Thread ids are kept to the narrower of the id width and the port width.
  localparam int TidKeepW = (THREAD_ID_BITS < csq_pkg::TID_W) ? THREAD_ID_BITS
                                                              : csq_pkg::TID_W;

  logic         q_push, q_full, q_pop, q_valid;
  csq_pkg::op_t q_wdata, q_rdata;

  // Front end: decode commands into operations.
  csq_front u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .thread_id_i (thread_id_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata)
  );

  // Operation queue between intake and execution.
  csq_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  // Back end: semaphore state, waiter ring and result register.
  csq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TID_KEEP_W  (TidKeepW)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .op_valid_i      (q_valid),
    .op_i            (q_rdata),
    .op_pop_o        (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .thread_id_res_o (thread_id_res_o),
    .last_o          (last_o)
  );

endmodule
